/* design/wrm_pkg.sv */
// Shared types and constants for the windowed rpm meter.
// Holds the transaction structs, the controller state type and all sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrm_pkg;

    // Sizing of the channel rings
    localparam int CHANNELS    = 4;
    localparam int WINDOW      = 5;
    localparam int CHAN_W      = 2;
    localparam int TIME_W      = 64;
    localparam int RATE_W      = 40;
    localparam int RPM_W       = 24;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int PROD_W      = RATE_W + CNT_W;
    localparam int ITER_W      = $clog2(PROD_W + 1);
    localparam int STORE_DEPTH = CHANNELS * WINDOW;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [RATE_W-1:0] RATE_RESET = 40'd12000000000;

    // Configuration port: 64-bit registers at byte address 8*i
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = APB_AW - 3;
    localparam logic [REG_IDX_W-1:0] REG_RATE_SCALE = 1'b0;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] edge_time_ns;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0] result_channel;
        logic [RPM_W-1:0]  rpm;
        logic              saturated;
    } rpm_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SPAN,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } wrm_state_t;

endpackage

`default_nettype wire

/* design/wrm_div.sv */
// Bit-serial restoring divider for the rpm quotient.
// One quotient bit per cycle.
// Depends on wrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrm_div
    import wrm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output logic                   done,
    output logic [PROD_W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [PROD_W-1:0] quo_reg;

    logic [TIME_W:0]   rem_shift;
    logic [TIME_W-1:0] rem_diff;
    logic              fits;
    logic [TIME_W-1:0] rem_next;
    logic [PROD_W-1:0] quo_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        rem_diff  = rem_shift[TIME_W-1:0] - divisor;
        fits      = (rem_shift >= {1'b0, divisor});
        rem_next  = fits ? rem_diff : rem_shift[TIME_W-1:0];
        quo_next  = {quo_reg[PROD_W-2:0], fits};
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* design/windowed_rpm_meter.sv */
// A sample is accepted in ST_IDLE and goes through ST_READ, ST_SPAN, ST_LOAD
// and the bit-serial divider in ST_DIV; its result is registered in ST_DONE.
// One sample is in work at a time: no new sample is taken until the current
// result has gone into the output register, where it waits while the next
// sample is taken. Reset clears the ring valid bits (rings read as zero), write
// positions, window-full flags and sets rate_scale to 12000000000.
`timescale 1ns / 1ps
`default_nettype none

module windowed_rpm_meter
    import wrm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Edge samples
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire sample_t           sample,
    // Rate results
    output logic                   result_valid,
    input  wire logic              result_ready,
    output rpm_result_t            result,
    // Configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    wrm_state_t state_reg, state_next;

    logic [RATE_W-1:0]   rate_scale_reg;

    logic [POS_W-1:0]    wpos_reg [CHANNELS];
    logic                full_reg [CHANNELS];
    logic [STORE_DEPTH-1:0] store_valid_reg;
    logic [TIME_W-1:0]   store_mem [STORE_DEPTH];

    logic [CHAN_W-1:0]   ch_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                chan_ok_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [POS_W-1:0]    slot_reg;
    logic [STORE_AW-1:0] rd_addr_reg;
    logic [STORE_AW-1:0] wr_addr_reg;
    logic [TIME_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic [TIME_W-1:0]   span_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                empty_reg;

    logic                out_valid_reg;
    rpm_result_t         out_reg;

    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [PROD_W-1:0]   quotient;
    logic                out_free;
    logic                cfg_write;

    logic                in_chan_ok;
    logic [POS_W-1:0]    in_pos;
    logic                in_full;
    logic [CNT_W-1:0]    in_count;
    logic [POS_W-1:0]    in_oldest;
    logic [TIME_W-1:0]   oldest;
    logic [POS_W-1:0]    pos_inc;
    logic                pos_wrap;
    logic                sat;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[APB_AW-1:3] == REG_RATE_SCALE);
    assign prdata    = (paddr[APB_AW-1:3] == REG_RATE_SCALE) ?
                       APB_DW'(rate_scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg <= RATE_RESET;
        end
        else if (cfg_write)
        begin
            rate_scale_reg <= pwdata[RATE_W-1:0];
        end
    end

    // Controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = sample_valid && sample_ready;

    // Look up the channel's ring position at acceptance
    always_comb
    begin
        in_chan_ok = (32'(sample.channel) < CHANNELS);
        in_pos     = wpos_reg[sample.channel];
        in_full    = full_reg[sample.channel];
        if (32'(in_pos) >= WINDOW)
        begin
            in_pos = '0;
        end
        in_count  = in_full ? CNT_W'(WINDOW) : CNT_W'(in_pos);
        in_oldest = in_full ? in_pos : '0;
    end

    // Capture the sample and ring addresses
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg      <= sample.channel;
            now_reg     <= sample.edge_time_ns;
            chan_ok_reg <= in_chan_ok;
            count_reg   <= in_chan_ok ? in_count : '0;
            slot_reg    <= in_pos;
            rd_addr_reg <= STORE_AW'(32'(sample.channel) * WINDOW + 32'(in_oldest));
            wr_addr_reg <= STORE_AW'(32'(sample.channel) * WINDOW + 32'(in_pos));
        end
    end

    // Ring store: registered read, then write of the new time
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rd_data_reg  <= store_mem[rd_addr_reg];
            rd_valid_reg <= store_valid_reg[rd_addr_reg];
        end
        if (state_reg == ST_SPAN && chan_ok_reg)
        begin
            store_mem[wr_addr_reg] <= now_reg;
        end
    end

    assign oldest   = rd_valid_reg ? rd_data_reg : '0;
    assign pos_inc  = slot_reg + 1'b1;
    assign pos_wrap = (32'(slot_reg) + 1 >= WINDOW);

    // Span and scaled count; advance the ring position
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SPAN)
        begin
            span_reg  <= now_reg - oldest;
            prod_reg  <= PROD_W'(rate_scale_reg) * PROD_W'(count_reg);
            empty_reg <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_valid_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wpos_reg[i] <= '0;
                full_reg[i] <= 1'b0;
            end
        end
        else if (state_reg == ST_SPAN && chan_ok_reg)
        begin
            store_valid_reg[wr_addr_reg] <= 1'b1;
            wpos_reg[ch_reg] <= pos_wrap ? '0 : pos_inc;
            if (pos_wrap)
            begin
                full_reg[ch_reg] <= 1'b1;
            end
        end
    end

    // Serial division of the scaled count by the span
    wrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Hold the result until the output transaction completes
    assign sat = |quotient[PROD_W-1:RPM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.result_channel <= ch_reg;
            if (empty_reg)
            begin
                out_reg.rpm       <= '0;
                out_reg.saturated <= 1'b0;
            end
            else
            begin
                out_reg.rpm       <= sat ? '1 : quotient[RPM_W-1:0];
                out_reg.saturated <= sat;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
